[src/sfmf_pkg.sv]
// Shared types and constants for the fused softmax with floor.
// No dependencies; every other file imports this package.
package sfmf_pkg;

  localparam int NUM_ACTIONS = 4;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 33;
  localparam int BETA_W      = 15;
  localparam int PROB_W      = 25;
  localparam int FRAC_W      = 24;
  localparam int WGT_W       = 33;
  localparam int PROD_W      = SUM_W + BETA_W;
  localparam int K_W         = 6;
  localparam int RED_STEPS   = 6;
  localparam int SERIES_TERMS = 12;
  localparam int EXP_LAT     = 1 + RED_STEPS + 3 * SERIES_TERMS + 1;
  localparam int DIV_LAT     = PROB_W;
  localparam int CNT_W       = $clog2(NUM_ACTIONS);
  localparam int TOT_W       = WGT_W + CNT_W;
  localparam int NUM1_W      = WGT_W + FRAC_W + 1;
  localparam int TOT2_W      = PROB_W + CNT_W;
  localparam int NUM2_W      = PROB_W + FRAC_W + 1;
  localparam int PIPE_LAT    = 2 + EXP_LAT + 2 + DIV_LAT + 2 + DIV_LAT + 1;

  localparam logic [BETA_W-1:0] BETA_RESET = 15'd256;
  localparam logic signed [SUM_W-1:0] START_MAX = -33'sd655360000;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_b_0;
    logic signed [VAL_W-1:0] value_b_1;
    logic signed [VAL_W-1:0] value_b_2;
    logic signed [VAL_W-1:0] value_b_3;
    logic signed [VAL_W-1:0] value_f_0;
    logic signed [VAL_W-1:0] value_f_1;
    logic signed [VAL_W-1:0] value_f_2;
    logic signed [VAL_W-1:0] value_f_3;
  } in_word_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob_0;
    logic [PROB_W-1:0] prob_1;
    logic [PROB_W-1:0] prob_2;
    logic [PROB_W-1:0] prob_3;
    logic              floor_applied;
  } out_word_t;

endpackage

[src/sfmf_exp.sv]
// One lane of the exponential: weight = exp(-dist*beta) in Q1.32.
// Range reduction by ln2, then a pipelined 12-term Horner series. Uses sfmf_pkg.
module sfmf_exp import sfmf_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SUM_W-1:0]  dist_i,
  input  logic [BETA_W-1:0] beta_i,
  output logic [WGT_W-1:0]  weight_o
);

  localparam int RED_W = 37;

  typedef struct packed {
    logic [31:0]    r;
    logic [K_W-1:0] k;
    logic           z;
  } side_t;

  logic [PROD_W-1:0] y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= PROD_W'(dist_i) * PROD_W'(beta_i);
  end

  // range reduction: k = y / ln2, one quotient bit per stage
  logic [RED_W-1:0] rem_q [RED_STEPS];
  logic [K_W-1:0]   kk_q  [RED_STEPS];
  logic             zz_q  [RED_STEPS];

  for (genvar s = 0; s < RED_STEPS; s++) begin : g_red
    localparam logic [RED_W-1:0] STEP = RED_W'(LN2_Q32) << (RED_STEPS - 1 - s);
    logic [RED_W-1:0] rem_in;
    logic [K_W-1:0]   k_in;
    logic             z_in;
    if (s == 0) begin : g_first
      assign rem_in = {y_q[28:0], 8'd0};
      assign k_in   = '0;
      assign z_in   = (y_q[PROD_W-1:29] != '0);
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign k_in   = kk_q[s-1];
      assign z_in   = zz_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= STEP) begin
          rem_q[s] <= rem_in - STEP;
          kk_q[s]  <= k_in | K_W'(1 << (RED_STEPS - 1 - s));
        end else begin
          rem_q[s] <= rem_in;
          kk_q[s]  <= k_in;
        end
        zz_q[s] <= z_in;
      end
    end
  end

  // Horner: p = 1 - (r*p >> 32) / n, n from 12 down to 1
  logic [31:0] t_q  [SERIES_TERMS];
  logic [31:0] tb_q [SERIES_TERMS];
  logic [31:0] q0_q [SERIES_TERMS];
  logic [32:0] p_q  [SERIES_TERMS];
  side_t       sa_q [SERIES_TERMS];
  side_t       sb_q [SERIES_TERMS];
  side_t       sc_q [SERIES_TERMS];

  for (genvar h = 0; h < SERIES_TERMS; h++) begin : g_term
    localparam int N = SERIES_TERMS - h;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
    logic [32:0] p_in;
    side_t       s_in;
    logic [64:0] prod_a;
    logic [64:0] prod_b;
    logic [35:0] rem_c;
    logic [31:0] q_c;
    if (h == 0) begin : g_first
      assign p_in = 33'h1_0000_0000;
      assign s_in = '{r: rem_q[RED_STEPS-1][31:0], k: kk_q[RED_STEPS-1],
                      z: zz_q[RED_STEPS-1]};
    end else begin : g_next
      assign p_in = p_q[h-1];
      assign s_in = sc_q[h-1];
    end
    assign prod_a = 65'(s_in.r) * 65'(p_in);
    assign prod_b = 65'(t_q[h]) * 65'(RECIP);
    // reciprocal estimate is low by at most one
    assign rem_c  = 36'(tb_q[h]) - 36'(q0_q[h]) * 36'(N);
    assign q_c    = q0_q[h] + 32'(rem_c >= 36'(N));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[h]  <= prod_a[63:32];
        sa_q[h] <= s_in;
        q0_q[h] <= prod_b[63:32];
        tb_q[h] <= t_q[h];
        sb_q[h] <= sa_q[h];
        p_q[h]  <= 33'h1_0000_0000 - 33'(q_c);
        sc_q[h] <= sb_q[h];
      end
    end
  end

  logic [WGT_W-1:0] w_q;
  side_t            s_last;
  assign s_last = sc_q[SERIES_TERMS-1];

  always_ff @(posedge clk_i) begin
    if (en_i) w_q <= s_last.z ? '0 : (p_q[SERIES_TERMS-1] >> s_last.k);
  end

  assign weight_o = w_q;

endmodule

[src/sfmf_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Needs num >> QW below den. Uses sfmf_pkg for parameter defaults only.
module sfmf_div import sfmf_pkg::*; #(
  parameter int NW = NUM1_W,
  parameter int DW = TOT_W,
  parameter int QW = PROB_W,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          ge;
    if (s == 0) begin : g_first
      assign rem_in  = DW'(num_i >> QW);
      assign low_in  = num_i[QW-1:0];
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end
    assign trial = {rem_in, low_in[QW-1-s]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        low_q[s]  <= low_in;
        den_q[s]  <= den_in;
        quo_q[s]  <= {quo_in[QW-2:0], ge};
        side_q[s] <= side_in;
      end
    end
  end

  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

[src/fused_softmax_with_floor.sv]
// Pipeline: input sums, distances from the max, exp lanes, merge, first
// divider chain, floor check, second divider chain (one bit a stage) and
// output register. Throughput: one word per cycle; all stages hold while the output word waits.
// Reset: asynchronous active low clears the valid chain and sets beta to 1.0.
// Top level; instantiates sfmf_exp and sfmf_div, uses sfmf_pkg.
module fused_softmax_with_floor import sfmf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BETA_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_data_o
);

  logic [BETA_W-1:0]   beta_q;
  logic [PIPE_LAT-1:0] vld_q;
  logic                en;

  assign en          = out_ready_i | ~out_valid_o;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) beta_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  logic signed [VAL_W-1:0] vb [NUM_ACTIONS];
  logic signed [VAL_W-1:0] vf [NUM_ACTIONS];
  assign vb[0] = in_data_i.value_b_0;
  assign vb[1] = in_data_i.value_b_1;
  assign vb[2] = in_data_i.value_b_2;
  assign vb[3] = in_data_i.value_b_3;
  assign vf[0] = in_data_i.value_f_0;
  assign vf[1] = in_data_i.value_f_1;
  assign vf[2] = in_data_i.value_f_2;
  assign vf[3] = in_data_i.value_f_3;

  logic signed [SUM_W-1:0] sum_q  [NUM_ACTIONS];
  logic [SUM_W-1:0]        dist_q [NUM_ACTIONS];
  logic signed [SUM_W-1:0] mx;

  always_comb begin
    mx = START_MAX;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (sum_q[i] > mx) mx = sum_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        sum_q[i]  <= SUM_W'(vb[i]) + SUM_W'(vf[i]);
        dist_q[i] <= SUM_W'(mx - sum_q[i]);
      end
    end
  end

  logic [WGT_W-1:0] wgt [NUM_ACTIONS];

  for (genvar i = 0; i < NUM_ACTIONS; i++) begin : g_exp
    sfmf_exp u_exp (
      .clk_i    (clk_i),
      .en_i     (en),
      .dist_i   (dist_q[i]),
      .beta_i   (beta_q),
      .weight_o (wgt[i])
    );
  end

  // merge: total of weights, then numerators for the first divide
  logic [WGT_W-1:0]  w_q [NUM_ACTIONS];
  logic [TOT_W-1:0]  tot_q;
  logic [TOT_W-1:0]  tot_sum;
  logic [NUM1_W-1:0] num1_q [NUM_ACTIONS];
  logic [TOT_W-1:0]  den1_q;

  always_comb begin
    tot_sum = '0;
    for (int i = 0; i < NUM_ACTIONS; i++) tot_sum = tot_sum + TOT_W'(wgt[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        w_q[i]    <= wgt[i];
        num1_q[i] <= (NUM1_W'(w_q[i]) << FRAC_W) + NUM1_W'(tot_q >> 1);
      end
      tot_q  <= tot_sum;
      // all weights zero: numerators are zero, a divisor of one gives zero
      den1_q <= (tot_q == '0) ? TOT_W'(1) : tot_q;
    end
  end

  logic [PROB_W-1:0] q1 [NUM_ACTIONS];
  logic              unused1 [NUM_ACTIONS];

  for (genvar i = 0; i < NUM_ACTIONS; i++) begin : g_div1
    sfmf_div #(.NW(NUM1_W), .DW(TOT_W), .QW(PROB_W), .SW(1)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num1_q[i]),
      .den_i  (den1_q),
      .side_i (1'b0),
      .quo_o  (q1[i]),
      .side_o (unused1[i])
    );
  end

  // floor check and second-pass numerators
  logic [PROB_W-1:0]  p1_q [NUM_ACTIONS];
  logic               any_q;
  logic               any_d;
  logic [TOT2_W-1:0]  t2;
  logic [NUM2_W-1:0]  num2_q [NUM_ACTIONS];
  logic [TOT2_W-1:0]  den2_q;
  logic [PROB_W:0]    side2_q [NUM_ACTIONS];

  always_comb begin
    any_d = 1'b0;
    t2    = '0;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (q1[i] == '0) any_d = 1'b1;
      t2 = t2 + TOT2_W'(p1_q[i]) + TOT2_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      any_q <= any_d;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        p1_q[i]    <= q1[i];
        num2_q[i]  <= (NUM2_W'(p1_q[i] + PROB_W'(1)) << FRAC_W) + NUM2_W'(t2 >> 1);
        side2_q[i] <= {any_q, p1_q[i]};
      end
      den2_q <= t2;
    end
  end

  logic [PROB_W-1:0] q2 [NUM_ACTIONS];
  logic [PROB_W:0]   side2 [NUM_ACTIONS];
  logic [PROB_W-1:0] pf [NUM_ACTIONS];

  for (genvar i = 0; i < NUM_ACTIONS; i++) begin : g_div2
    sfmf_div #(.NW(NUM2_W), .DW(TOT2_W), .QW(PROB_W), .SW(PROB_W + 1)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num2_q[i]),
      .den_i  (den2_q),
      .side_i (side2_q[i]),
      .quo_o  (q2[i]),
      .side_o (side2[i])
    );
    assign pf[i] = side2[i][PROB_W] ? q2[i] : side2[i][PROB_W-1:0];
  end

  out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.prob_0        <= pf[0];
      out_q.prob_1        <= pf[1];
      out_q.prob_2        <= pf[2];
      out_q.prob_3        <= pf[3];
      out_q.floor_applied <= side2[0][PROB_W];
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTH
  // without the floor every probability is nonzero
  a_nofloor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.floor_applied) |->
      (out_data_o.prob_0 != '0 && out_data_o.prob_1 != '0 &&
       out_data_o.prob_2 != '0 && out_data_o.prob_3 != '0))
    else $error("zero probability without floor");
  // after the floor pass no probability is zero either
  a_floor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.floor_applied) |->
      (out_data_o.prob_0 != '0 && out_data_o.prob_1 != '0 &&
       out_data_o.prob_2 != '0 && out_data_o.prob_3 != '0))
    else $error("zero probability after floor");
  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed under stall");
`endif

endmodule

[verif/fused_softmax_with_floor_tb.sv]
// Testbench for fused_softmax_with_floor: random and directed vector words,
// predicted in fixed point and checked in order. Depends on sfmf_pkg and the RTL.
`timescale 1ns / 100ps

module fused_softmax_with_floor_tb;
  import sfmf_pkg::*;

  localparam logic [BETA_W-1:0] BETA_MAX = 15'd25600;
  localparam longint unsigned ONE_Q32 = 64'd4294967296;
  localparam longint unsigned LN2 = 64'd2977044472;
  localparam int DRAIN_CYCLES = PIPE_LAT + 20;

  // Fixed-point softmax predictor with its own copy of beta.
  class softmax_scoreboard;
    logic [BETA_W-1:0] beta;
    out_word_t pending[$];
    int mismatches;

    function new();
      beta = BETA_RESET;
      mismatches = 0;
    endfunction

    function longint unsigned exp_neg(longint unsigned x);
      longint unsigned y, k, r, p, t;
      if (x >= (64'd32 << 24)) return 0;
      y = x << 8;
      k = y / LN2;
      r = y - k * LN2;
      p = ONE_Q32;
      for (int n = SERIES_TERMS; n >= 1; n--) begin
        t = (r * p) >> 32;
        t = t / n;
        p = ONE_Q32 - t;
      end
      if (k >= 63) return 0;
      return p >> k;
    endfunction

    function void note_input(in_word_t w);
      longint s[NUM_ACTIONS];
      longint unsigned wt[NUM_ACTIONS], p[NUM_ACTIONS];
      longint mx, v[2*NUM_ACTIONS];
      longint unsigned total, t2;
      bit fl;
      out_word_t o;
      v = '{w.value_b_0, w.value_b_1, w.value_b_2, w.value_b_3,
            w.value_f_0, w.value_f_1, w.value_f_2, w.value_f_3};
      mx = -64'sd655360000;
      total = 0;
      fl = 0;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        s[i] = v[i] + v[NUM_ACTIONS+i];
        if (s[i] > mx) mx = s[i];
      end
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        wt[i] = exp_neg(longint'(mx - s[i]) * longint'(beta));
        total += wt[i];
      end
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        p[i] = (total == 0) ? 0 : ((wt[i] << 24) + total / 2) / total;
        if (p[i] == 0) fl = 1;
      end
      if (fl) begin
        t2 = 0;
        for (int i = 0; i < NUM_ACTIONS; i++) begin
          p[i] += 1;
          t2 += p[i];
        end
        for (int i = 0; i < NUM_ACTIONS; i++) p[i] = ((p[i] << 24) + t2 / 2) / t2;
      end
      o.prob_0 = p[0][PROB_W-1:0];
      o.prob_1 = p[1][PROB_W-1:0];
      o.prob_2 = p[2][PROB_W-1:0];
      o.prob_3 = p[3][PROB_W-1:0];
      o.floor_applied = fl;
      pending.push_back(o);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp p=%h %h %h %h f=%b got p=%h %h %h %h f=%b",
                   exp_w.prob_0, exp_w.prob_1, exp_w.prob_2, exp_w.prob_3,
                   exp_w.floor_applied, got.prob_0, got.prob_1, got.prob_2,
                   got.prob_3, got.floor_applied);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [BETA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  out_word_t out_data_o;

  softmax_scoreboard sb = new();
  bit hold_off = 0;
  bit sink_free = 0;

  fused_softmax_with_floor uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Check on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Receiver: mostly ready, random stalls; on request a long hold-off or always ready.
  initial begin
    int run;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready_i <= 0;
      else if (sink_free) out_ready_i <= 1;
      else begin
        run = $urandom_range(0, 3);
        if (run == 0) out_ready_i <= 0;
        else out_ready_i <= 1;
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $signed($urandom);
      default: return $signed($urandom_range(0, 32'h00060000)) - 32'sh00030000;
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.value_b_0 = pick_value();
    w.value_b_1 = pick_value();
    w.value_b_2 = pick_value();
    w.value_b_3 = pick_value();
    w.value_f_0 = pick_value();
    w.value_f_1 = pick_value();
    w.value_f_2 = pick_value();
    w.value_f_3 = pick_value();
    return w;
  endfunction

  // Offer one word and hold it until accepted; caller is at a falling edge.
  task automatic send_word(in_word_t w);
    in_valid_i <= 1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(w);
    @(negedge clk_i);
  endtask

  task automatic send_gap();
    in_valid_i <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_beta(logic [BETA_W-1:0] b);
    cfg_we_i <= 1;
    cfg_data_i <= b;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.beta = b;
  endtask

  task automatic fill_all(logic signed [VAL_W-1:0] vb, logic signed [VAL_W-1:0] vf);
    in_word_t w;
    w = '{vb, vb, vb, vb, vf, vf, vf, vf};
    send_word(w);
  endtask

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++, count--) send_word(random_word());
      if ($urandom_range(0, 2) == 0) send_gap();
    end
  endtask

  initial begin
    in_word_t w;
    logic [BETA_W-1:0] betas[6];
    betas = '{15'd0, BETA_MAX, 15'd1, 15'd256, 15'd3000, 15'd64};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed, reset beta: extremes, all sums below start max, all equal
    fill_all(32'sh7fffffff, 32'sh7fffffff);
    fill_all(32'sh80000000, 32'sh80000000);
    fill_all(0, 0);
    fill_all(-32'sd655360000, 0);
    fill_all(32'sh80000000, 32'sh00010000);
    w = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000,
          32'sh7fffffff, 32'sh80000000, 0, -32'sh00010000};
    send_word(w);
    w = '{32'sh00100000, 0, 0, 0, 0, 0, 0, 0};
    send_word(w);
    w = '{32'sh00010000, 0, 32'sh00008000, -32'sh00010000, 0, 0, 0, 0};
    send_word(w);
    w = '{-32'sh7fffffff, -32'sh7fffffff, -32'sh7ffffff0, -32'sh7fffffff,
          -32'sh7fffffff, -32'sh7fffffff, -32'sh7fffffff, -32'sh7fffffff};
    send_word(w);
    drain();
    set_beta(15'h7fff);
    set_beta(0);
    w = '{32'sh7fffffff, 32'sh80000000, 0, 1, 2, 3, 4, 5};
    send_word(w);
    fill_all(32'sh80000000, 32'sh7fffffff);
    drain();
    set_beta(BETA_MAX);
    w = '{1, 0, 0, 0, 0, 0, 0, 0};
    send_word(w);
    w = '{32'sh00010000, 0, 0, 0, 0, 0, 0, 0};
    send_word(w);
    fill_all(32'sh80000000, 32'sh80000000);
    drain();

    // random phases over several gains
    foreach (betas[j]) begin
      set_beta(betas[j]);
      if (j == 2) begin
        // receiver holds off long enough to back up the pipeline
        fork
          begin
            hold_off = 1;
            repeat (PIPE_LAT * 3) @(negedge clk_i);
            hold_off = 0;
          end
          for (int i = 0; i < 150; i++) send_word(random_word());
        join
      end
      if (j == 4) sink_free = 1;
      random_phase(180);
      sink_free = 0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("fused_softmax_with_floor test passed");
    else
      $display("fused_softmax_with_floor test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("fused_softmax_with_floor test failed");
    $finish;
  end
endmodule
